>>> src/pwsw_pkg.sv
// Shared constants and a type for the pulse-width single-wire receiver.
package pwsw_pkg;

  // Width of the phase tick counter and of the stored high time.
  localparam int COUNT_WIDTH = 16;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Widths of the configuration registers and of the configuration port.
  localparam int TIMEOUT_WIDTH = 16;
  localparam int PERIOD_WIDTH  = 17;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = PERIOD_WIDTH;

  // Compare widths wide enough for both the counter and the register.
  localparam int TO_CMP_WIDTH  = (COUNT_WIDTH > TIMEOUT_WIDTH) ? COUNT_WIDTH : TIMEOUT_WIDTH;
  localparam int PER_CMP_WIDTH = (COUNT_WIDTH + 1 > PERIOD_WIDTH) ? COUNT_WIDTH + 1
                                                                  : PERIOD_WIDTH;

  // Configuration register indexes.
  localparam logic [CFG_IDX_WIDTH-1:0] REG_HEADER_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_HEADER_MIN     = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_BIT_TIMEOUT    = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PERIOD_MIN     = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PERIOD_MAX     = 3'd4;

  // Configuration reset values.
  localparam logic [TIMEOUT_WIDTH-1:0] HEADER_TIMEOUT_RST = 16'd7000;
  localparam logic [TIMEOUT_WIDTH-1:0] HEADER_MIN_RST     = 16'd2000;
  localparam logic [TIMEOUT_WIDTH-1:0] BIT_TIMEOUT_RST    = 16'd400;
  localparam logic [PERIOD_WIDTH-1:0]  PERIOD_MIN_RST     = 17'd120;
  localparam logic [PERIOD_WIDTH-1:0]  PERIOD_MAX_RST     = 17'd350;

  // Receiver phases.
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_HIGH   = 2'd2;
  localparam logic [1:0] PH_LOW    = 2'd3;

  // Event kinds.
  localparam logic [1:0] EV_BYTE  = 2'd0;
  localparam logic [1:0] EV_DONE  = 2'd1;
  localparam logic [1:0] EV_ABORT = 2'd2;

  // Index of the last bit of a received byte and the saturating byte count limit.
  localparam logic [2:0] LAST_BIT  = 3'd7;
  localparam logic [7:0] BYTES_MAX = 8'd255;

  typedef logic [COUNT_WIDTH-1:0] count_t;

endpackage

>>> src/pwsw_if.sv
// Valid/ready channel interfaces for samples, events and configuration writes.
interface pwsw_sample_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

interface pwsw_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] data_byte;
  logic [7:0] byte_count;

  modport source (output valid, output event_kind, output data_byte, output byte_count,
                  input ready);
  modport sink   (input valid, input event_kind, input data_byte, input byte_count,
                  output ready);
endinterface

interface pwsw_cfg_if
  import pwsw_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [CFG_IDX_WIDTH-1:0]  index;
  logic [CFG_DATA_WIDTH-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/pulse_width_single_wire_receiver.sv
// Top level of the pulse-width single-wire receiver: phase timing and byte assembly.
// An event is registered and appears on the output in the cycle after the sample that causes it.
// Throughput: one sample per cycle; a sample is taken whenever the event register
// is empty or is being drained in the same cycle.
// Reset (rst, synchronous, active high): idle phase, previous level high, all
// counters zero, configuration registers at their default values, no event pending.
module pulse_width_single_wire_receiver
  import pwsw_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  pwsw_sample_if.sink   pin,
  pwsw_event_if.source  events,
  pwsw_cfg_if.sink      cfg
);

  // Configuration registers.
  logic [TIMEOUT_WIDTH-1:0] header_timeout;
  logic [TIMEOUT_WIDTH-1:0] header_min;
  logic [TIMEOUT_WIDTH-1:0] bit_timeout;
  logic [PERIOD_WIDTH-1:0]  period_min;
  logic [PERIOD_WIDTH-1:0]  period_max;

  // Receiver state.
  logic [1:0] phase, phase_next;
  logic       prev_level;
  count_t     tick_count, tick_count_next;
  count_t     high_time, high_time_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] bytes_received, bytes_received_next;

  // Event register.
  logic       ev_valid;
  logic [1:0] ev_kind;
  logic [7:0] ev_data;
  logic [7:0] ev_count;

  // Combinational results for the current sample.
  logic                     sample_fire;
  logic                     emit;
  logic [1:0]               emit_kind;
  logic [7:0]               emit_data;
  count_t                   tick_bumped;
  logic                     header_to_hit;
  logic                     bit_to_hit;
  logic [PER_CMP_WIDTH-1:0] period_total;
  logic                     period_bad;
  logic [7:0]               shift_with_bit;
  logic [7:0]               bytes_inc;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_timeout <= HEADER_TIMEOUT_RST;
      header_min     <= HEADER_MIN_RST;
      bit_timeout    <= BIT_TIMEOUT_RST;
      period_min     <= PERIOD_MIN_RST;
      period_max     <= PERIOD_MAX_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_HEADER_TIMEOUT: header_timeout <= cfg.data[TIMEOUT_WIDTH-1:0];
        REG_HEADER_MIN:     header_min     <= cfg.data[TIMEOUT_WIDTH-1:0];
        REG_BIT_TIMEOUT:    bit_timeout    <= cfg.data[TIMEOUT_WIDTH-1:0];
        REG_PERIOD_MIN:     period_min     <= cfg.data[PERIOD_WIDTH-1:0];
        REG_PERIOD_MAX:     period_max     <= cfg.data[PERIOD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // A sample is taken whenever the event register can take a new event.
  assign pin.ready   = !ev_valid || events.ready;
  assign sample_fire = pin.valid && pin.ready;

  // Shared arithmetic: saturating tick count, timeout compares, period window, bit insertion, byte count.
  assign tick_bumped    = (tick_count == COUNT_MAX) ? tick_count : tick_count + 1'b1;
  assign header_to_hit  = TO_CMP_WIDTH'(tick_bumped) >= TO_CMP_WIDTH'(header_timeout);
  assign bit_to_hit     = TO_CMP_WIDTH'(tick_bumped) >= TO_CMP_WIDTH'(bit_timeout);
  assign period_total   = PER_CMP_WIDTH'(high_time) + PER_CMP_WIDTH'(tick_count);
  assign period_bad     = (period_total < PER_CMP_WIDTH'(period_min)) ||
                          (period_total > PER_CMP_WIDTH'(period_max));
  assign shift_with_bit = shift_byte | (8'(high_time > tick_count) << bit_index);
  assign bytes_inc      = (bytes_received == BYTES_MAX) ? bytes_received
                                                        : bytes_received + 8'd1;

  // Phase machine: next state and the event caused by this sample.
  always_comb begin
    phase_next          = phase;
    tick_count_next     = tick_count;
    high_time_next      = high_time;
    shift_byte_next     = shift_byte;
    bit_index_next      = bit_index;
    bytes_received_next = bytes_received;
    emit                = 1'b0;
    emit_kind           = EV_ABORT;
    emit_data           = 8'd0;
    case (phase)
      PH_IDLE: begin
        if (prev_level && !pin.pin_level) begin
          phase_next      = PH_HEADER;
          tick_count_next = count_t'(1);
        end
      end
      PH_HEADER: begin
        if (!pin.pin_level) begin
          tick_count_next = tick_bumped;
          if (header_to_hit) begin
            phase_next = PH_IDLE;
          end
        end else if (TO_CMP_WIDTH'(tick_count) < TO_CMP_WIDTH'(header_min)) begin
          phase_next = PH_IDLE;
        end else begin
          bytes_received_next = 8'd0;
          bit_index_next      = 3'd0;
          shift_byte_next     = 8'd0;
          phase_next          = PH_HIGH;
          tick_count_next     = count_t'(1);
        end
      end
      PH_HIGH: begin
        if (pin.pin_level) begin
          tick_count_next = tick_bumped;
          if (bit_to_hit) begin
            emit       = 1'b1;
            emit_kind  = (bytes_received != 8'd0 && bit_index == 3'd0) ? EV_DONE : EV_ABORT;
            phase_next = PH_IDLE;
          end
        end else begin
          high_time_next  = tick_count;
          tick_count_next = count_t'(1);
          phase_next      = PH_LOW;
        end
      end
      default: begin
        if (!pin.pin_level) begin
          tick_count_next = tick_bumped;
          if (bit_to_hit) begin
            emit       = 1'b1;
            phase_next = PH_IDLE;
          end
        end else if (period_bad) begin
          emit       = 1'b1;
          phase_next = PH_IDLE;
        end else begin
          bit_index_next = bit_index + 3'd1;
          if (bit_index == LAST_BIT) begin
            bytes_received_next = bytes_inc;
            shift_byte_next     = 8'd0;
            emit                = 1'b1;
            emit_kind           = EV_BYTE;
            emit_data           = shift_with_bit;
          end else begin
            shift_byte_next = shift_with_bit;
          end
          phase_next      = PH_HIGH;
          tick_count_next = count_t'(1);
        end
      end
    endcase
  end

  // State registers advance on every sample transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      prev_level     <= 1'b1;
      tick_count     <= '0;
      high_time      <= '0;
      shift_byte     <= 8'd0;
      bit_index      <= 3'd0;
      bytes_received <= 8'd0;
    end else if (sample_fire) begin
      phase          <= phase_next;
      prev_level     <= pin.pin_level;
      tick_count     <= tick_count_next;
      high_time      <= high_time_next;
      shift_byte     <= shift_byte_next;
      bit_index      <= bit_index_next;
      bytes_received <= bytes_received_next;
    end
  end

  // Event register: loaded by an event, cleared when its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (sample_fire && emit) begin
      ev_valid <= 1'b1;
    end else if (events.ready) begin
      ev_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_fire && emit) begin
      ev_kind  <= emit_kind;
      ev_data  <= emit_data;
      ev_count <= bytes_received_next;
    end
  end

  assign events.valid      = ev_valid;
  assign events.event_kind = ev_kind;
  assign events.data_byte  = ev_data;
  assign events.byte_count = ev_count;

  // A pending event always carries one of the three defined kinds.
  a_kind_defined: assert property (@(posedge clk) disable iff (rst)
    ev_valid |-> (ev_kind == EV_BYTE || ev_kind == EV_DONE || ev_kind == EV_ABORT))
    else $error("event register holds an undefined kind");

  // Samples taken in idle or in the header never produce an event.
  a_quiet_phases: assert property (@(posedge clk) disable iff (rst)
    (sample_fire && (phase == PH_IDLE || phase == PH_HEADER)) |-> !emit)
    else $error("event produced outside the bit phases");

  // A frame done or abort event sends the receiver back to idle.
  a_end_to_idle: assert property (@(posedge clk) disable iff (rst)
    (sample_fire && emit && emit_kind != EV_BYTE) |=> (phase == PH_IDLE))
    else $error("receiver did not return to idle after a frame end");

  // A data byte event is only produced at the last bit of a byte.
  a_byte_boundary: assert property (@(posedge clk) disable iff (rst)
    (sample_fire && emit && emit_kind == EV_BYTE) |=> (bit_index == 3'd0 && phase == PH_HIGH))
    else $error("data byte emitted off a byte boundary");

endmodule
